// ----- sv/olt_pkg.sv -----
// shared constants, codes and controller/datapath interface types
package olt_pkg;

   // store size and derived widths
   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int CMD_W    = 3;
   localparam int POS_W    = 7;
   localparam int ELEM_W   = 8;
   localparam int RES_W    = 7;
   localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

   // pointer load source
   typedef enum logic [1:0] {
      PTR_ZERO   = 2'd0,
      PTR_LEN_M1 = 2'd1,
      PTR_POS_M1 = 2'd2
   } ptr_src_type;

   // controller to datapath
   typedef struct packed {
      logic        load;
      logic        ptr_load;
      ptr_src_type ptr_src;
      logic        rd_issue;
      logic        dir_down;
      logic        shift_up;
      logic        shift_dn;
      logic        wr_value;
      logic        cap_read;
      logic        scan;
      logic        set_ok;
      logic        len_inc;
      logic        len_dec;
      logic        len_clear;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             ins_ok;
      logic             rd_ok;
      logic             ins_no_shift;
      logic             del_no_shift;
      logic             len_zero;
      logic             ptr_at_pos_m1;
      logic             ptr_at_len_m1;
   } dp_status_type;

endpackage

// ----- sv/olt_datapath.sv -----
// element store, length, walk pointer and result registers
module olt_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  olt_pkg::ctrl_cmd_type              ctl,
   output olt_pkg::dp_status_type             status,
   input  logic [olt_pkg::CMD_W-1:0]          req_cmd,
   input  logic [olt_pkg::POS_W-1:0]          req_position,
   input  logic [olt_pkg::ELEM_W-1:0]         req_elem_value,
   output logic                               rsp_ok,
   output logic [olt_pkg::ELEM_W-1:0]         rsp_read_value,
   output logic [olt_pkg::RES_W-1:0]          rsp_found_index,
   output logic [olt_pkg::RES_W-1:0]          rsp_cur_length
);

   // element store
   logic [olt_pkg::ELEM_W-1:0] mem [olt_pkg::CAPACITY];

   // request registers
   logic [olt_pkg::CMD_W-1:0]  cmd_ff;
   logic [olt_pkg::POS_W-1:0]  pos_ff;
   logic [olt_pkg::ELEM_W-1:0] val_ff;

   // control registers
   logic [olt_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [olt_pkg::IDX_W-1:0]  ptr_ff, ptr_in;
   logic                       rvalid_ff;

   // read pipeline and results
   logic [olt_pkg::IDX_W-1:0]  ridx_ff;
   logic [olt_pkg::ELEM_W-1:0] rdata_ff;
   logic                       ok_ff;
   logic [olt_pkg::ELEM_W-1:0] rd_ff;
   logic [olt_pkg::LEN_W-1:0]  fi_ff;
   logic                       found_ff;

   // derived values
   logic [olt_pkg::CMP_W-1:0]  pos_ext, len_ext, pos_m1_ext, fi_ext;
   logic [olt_pkg::IDX_W-1:0]  pos_m1, len_m1;
   logic [olt_pkg::LEN_W-1:0]  len_m1_w, ptr_inc_l, ridx_inc_l;
   logic                       wr_en, match;
   logic [olt_pkg::IDX_W-1:0]  wr_addr;
   logic [olt_pkg::ELEM_W-1:0] wr_data;

   assign pos_ext    = olt_pkg::CMP_W'(pos_ff);
   assign len_ext    = olt_pkg::CMP_W'(len_ff);
   assign fi_ext     = olt_pkg::CMP_W'(fi_ff);
   assign pos_m1_ext = pos_ext - olt_pkg::CMP_W'(1);
   assign pos_m1     = pos_m1_ext[olt_pkg::IDX_W-1:0];
   assign len_m1_w   = len_ff - olt_pkg::LEN_W'(1);
   assign len_m1     = len_m1_w[olt_pkg::IDX_W-1:0];
   assign ptr_inc_l  = olt_pkg::LEN_W'(ptr_ff) + olt_pkg::LEN_W'(1);
   assign ridx_inc_l = olt_pkg::LEN_W'(ridx_ff) + olt_pkg::LEN_W'(1);

   // status toward the controller
   always_comb begin
      status.cmd           = cmd_ff;
      status.ins_ok        = (pos_ff != '0) && (pos_ext <= len_ext + olt_pkg::CMP_W'(1))
                             && (len_ext < olt_pkg::CMP_W'(olt_pkg::CAPACITY));
      status.rd_ok         = (pos_ff != '0) && (pos_ext <= len_ext);
      status.ins_no_shift  = (pos_ext == len_ext + olt_pkg::CMP_W'(1));
      status.del_no_shift  = (pos_ext == len_ext);
      status.len_zero      = (len_ff == '0);
      status.ptr_at_pos_m1 = (ptr_ff == pos_m1);
      status.ptr_at_len_m1 = (ptr_inc_l == len_ff);
   end

   // store write port: shifted beat or the inserted value
   always_comb begin
      wr_en   = ((ctl.shift_up || ctl.shift_dn) && rvalid_ff) || ctl.wr_value;
      wr_data = ctl.wr_value ? val_ff : rdata_ff;
      if (ctl.wr_value) begin
         wr_addr = pos_m1;
      end else if (ctl.shift_up) begin
         wr_addr = ridx_ff + olt_pkg::IDX_W'(1);
      end else begin
         wr_addr = ridx_ff - olt_pkg::IDX_W'(1);
      end
   end

   // store with registered read
   always_ff @(posedge clock) begin
      if (ctl.rd_issue) begin
         rdata_ff <= mem[ptr_ff];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // walk pointer next value
   always_comb begin
      ptr_in = ptr_ff;
      priority if (ctl.ptr_load) begin
         unique case (ctl.ptr_src)
            olt_pkg::PTR_LEN_M1: ptr_in = len_m1;
            olt_pkg::PTR_POS_M1: ptr_in = pos_m1;
            default:             ptr_in = '0;
         endcase
      end else if (ctl.rd_issue) begin
         ptr_in = ctl.dir_down ? ptr_ff - olt_pkg::IDX_W'(1) : ptr_ff + olt_pkg::IDX_W'(1);
      end
   end

   // length next value
   always_comb begin
      len_in = len_ff;
      priority if (ctl.len_clear) begin
         len_in = '0;
      end else if (ctl.len_inc) begin
         len_in = len_ff + olt_pkg::LEN_W'(1);
      end else if (ctl.len_dec) begin
         len_in = len_m1_w;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         len_ff    <= len_in;
         rvalid_ff <= ctl.rd_issue;
      end
   end

   assign match = ctl.scan && rvalid_ff && (rdata_ff == val_ff);

   // request capture, read index and results
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (ctl.rd_issue) begin
         ridx_ff <= ptr_ff;
      end
      if (ctl.load) begin
         cmd_ff   <= req_cmd;
         pos_ff   <= req_position;
         val_ff   <= req_elem_value;
         ok_ff    <= 1'b0;
         rd_ff    <= '0;
         fi_ff    <= '0;
         found_ff <= 1'b0;
      end else begin
         if (ctl.set_ok) begin
            ok_ff <= 1'b1;
         end
         if (ctl.cap_read) begin
            rd_ff <= rdata_ff;
         end
         // locate keeps the first hit, count adds every hit
         if (match) begin
            if (cmd_ff == olt_pkg::CMD_COUNT) begin
               fi_ff <= fi_ff + olt_pkg::LEN_W'(1);
            end else if (!found_ff) begin
               fi_ff    <= ridx_inc_l;
               found_ff <= 1'b1;
            end
         end
      end
   end

   // result ports
   assign rsp_ok          = ok_ff;
   assign rsp_read_value  = rd_ff;
   assign rsp_found_index = fi_ext[olt_pkg::RES_W-1:0];
   assign rsp_cur_length  = len_ext[olt_pkg::RES_W-1:0];

endmodule

// ----- sv/olt_ctrl.sv -----
// command sequencer for the list operations
module olt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   input  olt_pkg::dp_status_type status,
   output olt_pkg::ctrl_cmd_type  ctl
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_DECODE   = 12'b0000_0000_0010,
      ST_FETCH    = 12'b0000_0000_0100,
      ST_GRAB     = 12'b0000_0000_1000,
      ST_SHIFT_DN = 12'b0000_0001_0000,
      ST_DRAIN_DN = 12'b0000_0010_0000,
      ST_SHIFT_UP = 12'b0000_0100_0000,
      ST_DRAIN_UP = 12'b0000_1000_0000,
      ST_PUT      = 12'b0001_0000_0000,
      ST_SCAN     = 12'b0010_0000_0000,
      ST_SCAN_END = 12'b0100_0000_0000,
      ST_DONE     = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            unique case (status.cmd)
               olt_pkg::CMD_INSERT: begin
                  if (status.ins_ok) begin
                     if (status.ins_no_shift) begin
                        state_in = ST_PUT;
                     end else begin
                        ctl.ptr_load = 1'b1;
                        ctl.ptr_src  = olt_pkg::PTR_LEN_M1;
                        state_in     = ST_SHIFT_UP;
                     end
                  end
               end
               olt_pkg::CMD_DELETE, olt_pkg::CMD_GET: begin
                  if (status.rd_ok) begin
                     ctl.ptr_load = 1'b1;
                     ctl.ptr_src  = olt_pkg::PTR_POS_M1;
                     state_in     = ST_FETCH;
                  end
               end
               olt_pkg::CMD_LOCATE, olt_pkg::CMD_COUNT: begin
                  ctl.set_ok = 1'b1;
                  if (!status.len_zero) begin
                     ctl.ptr_load = 1'b1;
                     ctl.ptr_src  = olt_pkg::PTR_ZERO;
                     state_in     = ST_SCAN;
                  end
               end
               olt_pkg::CMD_CLEAR: begin
                  ctl.len_clear = 1'b1;
                  ctl.set_ok    = 1'b1;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         // read the addressed element, pointer moves on to the next one
         ST_FETCH: begin
            ctl.rd_issue = 1'b1;
            state_in     = ST_GRAB;
         end
         ST_GRAB: begin
            ctl.cap_read = 1'b1;
            ctl.set_ok   = 1'b1;
            if (status.cmd == olt_pkg::CMD_DELETE) begin
               if (status.del_no_shift) begin
                  ctl.len_dec = 1'b1;
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_SHIFT_DN;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         // move later elements down one slot
         ST_SHIFT_DN: begin
            ctl.rd_issue = 1'b1;
            ctl.shift_dn = 1'b1;
            if (status.ptr_at_len_m1) begin
               state_in = ST_DRAIN_DN;
            end
         end
         ST_DRAIN_DN: begin
            ctl.shift_dn = 1'b1;
            ctl.len_dec  = 1'b1;
            state_in     = ST_DONE;
         end
         // move elements from the tail up one slot
         ST_SHIFT_UP: begin
            ctl.rd_issue = 1'b1;
            ctl.dir_down = 1'b1;
            ctl.shift_up = 1'b1;
            if (status.ptr_at_pos_m1) begin
               state_in = ST_DRAIN_UP;
            end
         end
         ST_DRAIN_UP: begin
            ctl.shift_up = 1'b1;
            state_in     = ST_PUT;
         end
         ST_PUT: begin
            ctl.wr_value = 1'b1;
            ctl.len_inc  = 1'b1;
            ctl.set_ok   = 1'b1;
            state_in     = ST_DONE;
         end
         // compare every element against the search byte
         ST_SCAN: begin
            ctl.rd_issue = 1'b1;
            ctl.scan     = 1'b1;
            if (status.ptr_at_len_m1) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            ctl.scan = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);

endmodule

// ----- sv/ordered_list_table_unit.sv -----
// ordered byte list top level: sequencer plus store datapath
//
// One command is taken at a time: a beat is accepted when start is high and
// busy is low, and its single result appears on the rsp_ ports for exactly one
// cycle with rsp_strobe high; the receiver cannot stall, so results must be
// taken as they come. The store is a memory with one read and one write port
// and a registered read, walked one element per cycle. Insert moves the
// elements from the tail down to position p up one slot, then writes the
// value (no shift when appending); delete reads position p, then moves later
// elements down one slot (no shift at the last position); get reads one
// element; locate and count compare every element (none on an empty list);
// clear and rejected commands go straight to the result. busy falls the cycle
// after the strobe. Stored bytes have no reset; only the length clears.
module ordered_list_table_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [olt_pkg::CMD_W-1:0]    req_cmd,
   input  logic [olt_pkg::POS_W-1:0]    req_position,
   input  logic [olt_pkg::ELEM_W-1:0]   req_elem_value,
   output logic                         rsp_strobe,
   output logic                         rsp_ok,
   output logic [olt_pkg::ELEM_W-1:0]   rsp_read_value,
   output logic [olt_pkg::RES_W-1:0]    rsp_found_index,
   output logic [olt_pkg::RES_W-1:0]    rsp_cur_length
);

   olt_pkg::ctrl_cmd_type  ctl;
   olt_pkg::dp_status_type status;

   // sequencer
   olt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .status     (status),
      .ctl        (ctl)
   );

   // store and result datapath
   olt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_position    (req_position),
      .req_elem_value  (req_elem_value),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_cur_length  (rsp_cur_length)
   );

endmodule
